### rtl/frame_gated_pointer_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame gated pointer tracker.
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_GATED_POINTER_TRACKER_UNIT_ASSERT_SVH
`define FRAME_GATED_POINTER_TRACKER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge.
`define FGPT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define FGPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fgpt_pkg.sv
// ----------------------------------------------------------------------------
// fgpt_pkg
// Constants, register indexes and the axis clamp helper of the pointer tracker.
// ----------------------------------------------------------------------------
package fgpt_pkg;

    localparam int unsigned InDataW  = 48;
    localparam int unsigned OutDataW = 112;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 9;

    localparam logic [7:0] LatchClearLine = 8'd180;
    localparam logic [7:0] SettleOpenLine = 8'd200;

    // Reset values of the configuration registers.
    localparam logic [8:0] XLowerReset  = 9'd0;
    localparam logic [8:0] XUpperReset  = 9'd319;
    localparam logic [7:0] YLowerReset  = 8'd0;
    localparam logic [7:0] YUpperReset  = 8'd199;
    localparam logic [8:0] XStartReset  = 9'd160;
    localparam logic [7:0] YStartReset  = 8'd100;
    localparam logic [1:0] WarmupReset  = 2'd2;
    localparam logic [7:0] SettleReset  = 8'd26;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_X_LOWER  = 3'd0,
        CFG_X_UPPER  = 3'd1,
        CFG_Y_LOWER  = 3'd2,
        CFG_Y_UPPER  = 3'd3,
        CFG_X_START  = 3'd4,
        CFG_Y_START  = 3'd5,
        CFG_WARMUP   = 3'd6,
        CFG_SETTLE   = 3'd7
    } t_cfg_idx;

    // Moves a position by a signed delta, clamping against the bounds.
    // Positions and bounds arrive zero extended to ten bits.
    function automatic logic [9:0] move_axis(input logic [9:0] pos,
                                             input logic signed [7:0] delta,
                                             input logic [9:0] lo,
                                             input logic [9:0] hi);
        logic signed [11:0] p;
        logic signed [11:0] l;
        logic signed [11:0] h;
        logic signed [11:0] d;
        logic signed [11:0] r;
        p = signed'({2'b00, pos});
        l = signed'({2'b00, lo});
        h = signed'({2'b00, hi});
        d = signed'({{4{delta[7]}}, delta});
        if (delta[7]) begin
            r = (p < l - d) ? l : p + d;
        end else begin
            r = (p > h - d) ? h : p + d;
        end
        return r[9:0];
    endfunction

endpackage

### rtl/frame_gated_pointer_tracker_unit.sv
// ----------------------------------------------------------------------------
// frame_gated_pointer_tracker_unit
// An accepted poll's result beat is registered and valid in the next cycle.
// Throughput: one poll per cycle; the state update and clamp sit between the
// state registers and the output register. While the sink stalls, a full
// output register holds the poll input off.
// Reset (synchronous, active low) loads the register defaults and the start
// position and clears the latch, the settle window and the counters.
// ----------------------------------------------------------------------------
module frame_gated_pointer_tracker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [fgpt_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [fgpt_pkg::CfgDataW-1:0]     i_cfg_wdata,
    // Poll input.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raster_line, ms_dx, ms_dy, ms_btn, joy_dx, joy_dy,
    // joy_buttons, zero fill
    input  logic [fgpt_pkg::InDataW-1:0]      s_axis_tdata,
    // Result output.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pos_x, pos_y, button_bits, sampled, settling, source_bits, sum_dx,
    // sum_dy, sample_total, move_total, mouse_total, joy_total, zero fill
    output logic [fgpt_pkg::OutDataW-1:0]     m_axis_tdata
);

    // Configuration registers.
    logic [8:0]  r_x_lo, r_x_hi;
    logic [7:0]  r_y_lo, r_y_hi;
    logic [7:0]  r_settle_lines;

    // Tracker state.
    logic [8:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [3:0]  r_buttons, n_buttons;
    logic        r_latched, n_latched;
    logic        r_settle, n_settle;
    logic [7:0]  r_settle_start, n_settle_start;
    logic [1:0]  r_warm_left, n_warm_left;
    logic [1:0]  r_sources, n_sources;
    logic [7:0]  r_dx, n_dx;
    logic [7:0]  r_dy, n_dy;
    logic [15:0] r_evt [4];
    logic [15:0] n_evt [4];

    logic                              r_out_valid;
    logic [fgpt_pkg::OutDataW-1:0]     r_out_data;

    logic        s_fire;
    logic        take;
    logic [7:0]  line;
    logic [7:0]  mdx, mdy, jdx, jdy;
    logic [1:0]  mb, jb;
    logic        warm;
    logic        lat_eff;
    logic        win_open;
    logic [7:0]  line_gap;
    logic [9:0]  x_moved, y_moved;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign line = s_axis_tdata[7:0];

    always_comb begin
        lat_eff  = r_latched && !(line < fgpt_pkg::LatchClearLine && !r_settle);
        win_open = !lat_eff && !r_settle && (line >= fgpt_pkg::SettleOpenLine);
        line_gap = line - r_settle_start;
        take     = !lat_eff && r_settle && (line_gap >= r_settle_lines);
        warm     = (r_warm_left != 2'd0);

        // During warmup the whole sample counts as zero motion and no buttons.
        mdx = warm ? 8'd0 : s_axis_tdata[15:8];
        mdy = warm ? 8'd0 : s_axis_tdata[23:16];
        mb  = warm ? 2'd0 : s_axis_tdata[25:24];
        jdx = warm ? 8'd0 : s_axis_tdata[33:26];
        jdy = warm ? 8'd0 : s_axis_tdata[41:34];
        jb  = warm ? 2'd0 : s_axis_tdata[43:42];

        n_x            = r_x;
        n_y            = r_y;
        n_buttons      = r_buttons;
        n_latched      = lat_eff;
        n_settle       = r_settle || win_open;
        n_settle_start = win_open ? line : r_settle_start;
        n_warm_left    = r_warm_left;
        n_sources      = r_sources;
        n_dx           = r_dx;
        n_dy           = r_dy;
        for (int k = 0; k < 4; k++) begin
            n_evt[k] = r_evt[k];
        end

        x_moved = fgpt_pkg::move_axis({1'b0, r_x}, signed'(mdx + jdx),
                                      {1'b0, r_x_lo}, {1'b0, r_x_hi});
        y_moved = fgpt_pkg::move_axis({2'b00, r_y}, signed'(mdy + jdy),
                                      {2'b00, r_y_lo}, {2'b00, r_y_hi});

        if (take) begin
            n_dx      = mdx + jdx;
            n_dy      = mdy + jdy;
            n_sources = {(jdx != 8'd0) || (jdy != 8'd0) || (jb != 2'd0),
                         (mdx != 8'd0) || (mdy != 8'd0) || (mb != 2'd0)};
            if (warm) begin
                n_warm_left = r_warm_left - 2'd1;
            end
            // A nonzero sum moves both axes, so an axis above its upper bound clamps too.
            if (n_dx != 8'd0 || n_dy != 8'd0) begin
                n_x      = x_moved[8:0];
                n_y      = y_moved[7:0];
                n_evt[1] = r_evt[1] + 16'd1;
            end
            if (n_sources[0]) begin
                n_evt[2] = r_evt[2] + 16'd1;
            end
            if (n_sources[1]) begin
                n_evt[3] = r_evt[3] + 16'd1;
            end
            n_evt[0]  = r_evt[0] + 16'd1;
            n_buttons = {jb, mb};
            n_settle  = 1'b0;
            n_latched = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo         <= fgpt_pkg::XLowerReset;
            r_x_hi         <= fgpt_pkg::XUpperReset;
            r_y_lo         <= fgpt_pkg::YLowerReset;
            r_y_hi         <= fgpt_pkg::YUpperReset;
            r_settle_lines <= fgpt_pkg::SettleReset;
            r_x            <= fgpt_pkg::XStartReset;
            r_y            <= fgpt_pkg::YStartReset;
            r_buttons      <= 4'd0;
            r_latched      <= 1'b0;
            r_settle       <= 1'b0;
            r_settle_start <= 8'd0;
            r_warm_left    <= fgpt_pkg::WarmupReset;
            r_sources      <= 2'd0;
            r_dx           <= 8'd0;
            r_dy           <= 8'd0;
            for (int k = 0; k < 4; k++) begin
                r_evt[k] <= 16'd0;
            end
            r_out_valid    <= 1'b0;
        end else begin
            if (s_fire) begin
                r_x            <= n_x;
                r_y            <= n_y;
                r_buttons      <= n_buttons;
                r_latched      <= n_latched;
                r_settle       <= n_settle;
                r_settle_start <= n_settle_start;
                r_warm_left    <= n_warm_left;
                r_sources      <= n_sources;
                r_dx           <= n_dx;
                r_dy           <= n_dy;
                for (int k = 0; k < 4; k++) begin
                    r_evt[k] <= n_evt[k];
                end
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
            // A start register write loads the live position or warmup count;
            // the start values themselves only matter at reset.
            if (i_cfg_we) begin
                unique case (fgpt_pkg::t_cfg_idx'(i_cfg_addr))
                    fgpt_pkg::CFG_X_LOWER: r_x_lo <= i_cfg_wdata;
                    fgpt_pkg::CFG_X_UPPER: r_x_hi <= i_cfg_wdata;
                    fgpt_pkg::CFG_Y_LOWER: r_y_lo <= i_cfg_wdata[7:0];
                    fgpt_pkg::CFG_Y_UPPER: r_y_hi <= i_cfg_wdata[7:0];
                    fgpt_pkg::CFG_X_START: r_x <= i_cfg_wdata;
                    fgpt_pkg::CFG_Y_START: r_y <= i_cfg_wdata[7:0];
                    fgpt_pkg::CFG_WARMUP: r_warm_left <= i_cfg_wdata[1:0];
                    fgpt_pkg::CFG_SETTLE: r_settle_lines <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // The result beat carries the state as it stands after this poll.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= {7'd0, n_evt[3], n_evt[2], n_evt[1], n_evt[0],
                           n_dy, n_dx, n_sources, n_settle, take,
                           n_buttons, n_y, n_x};
        end
    end

`include "frame_gated_pointer_tracker_unit_assert.svh"

    `FGPT_ASSERT_ALWAYS(a_latch_settle_excl, !(r_latched && r_settle),
        "settle window open while the frame latch is set")
    `FGPT_ASSERT_NEXT(a_sample_count, s_fire && take,
        r_evt[0] == $past(r_evt[0]) + 16'd1,
        "sample counter did not advance on a sample")
    `FGPT_ASSERT_NEXT(a_pos_hold, s_fire && !take && !i_cfg_we,
        $stable(r_x) && $stable(r_y),
        "position changed on a poll without a sample")
    `FGPT_ASSERT_NEXT(a_sample_latches, s_fire && take && !i_cfg_we,
        r_latched && !r_settle,
        "sample did not set the latch and close the settle window")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: frame gated pointer tracker
// Streams raster polls into the tracker and checks every result beat against
// a cycle-free model of the frame latch, settle window, clamp and counters,
// or its typed row of the short directed table that comes first; then random
// frame sweeps under several register settings, random gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;

    // Packed structs list the fields from the top bit down, so the first
    // field of the stream layout sits in the lowest bits.
    typedef struct packed {
        logic [1:0]        jbtn;
        logic signed [7:0] jdy;
        logic signed [7:0] jdx;
        logic [1:0]        mbtn;
        logic signed [7:0] mdy;
        logic signed [7:0] mdx;
        logic [7:0]        line;
    } t_poll;

    typedef struct packed {
        logic [15:0]       n_joy;
        logic [15:0]       n_mouse;
        logic [15:0]       n_move;
        logic [15:0]       n_samp;
        logic signed [7:0] sdy;
        logic signed [7:0] sdx;
        logic [1:0]        src;
        logic              settling;
        logic              sampled;
        logic [3:0]        btn;
        logic [7:0]        pos_y;
        logic [8:0]        pos_x;
    } t_report;

    typedef struct {
        int line, mdx, mdy, mb, jdx, jdy, jb;
        bit typed;
        int px, py, smp, stl, nsamp;
    } t_dir_row;

    localparam int DirRows = 26;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [fgpt_pkg::CfgAddrW-1:0] i_cfg_addr = fgpt_pkg::CFG_X_LOWER;
    logic [fgpt_pkg::CfgDataW-1:0] i_cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // raster_line, ms_dx, ms_dy, ms_btn, joy_dx, joy_dy,
    // joy_buttons, zero fill
    logic [fgpt_pkg::InDataW-1:0]  s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // pos_x, pos_y, button_bits, sampled, settling, source_bits, sum_dx,
    // sum_dy, sample_total, move_total, mouse_total, joy_total, zero fill
    logic [fgpt_pkg::OutDataW-1:0] m_axis_tdata;

    frame_gated_pointer_tracker_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Tracker model state and its copy of the registers.
    logic [8:0]  cfg_xlo, cfg_xhi, cfg_xstart;
    logic [7:0]  cfg_ylo, cfg_yhi, cfg_ystart, cfg_settle;
    logic [1:0]  cfg_warm;
    logic [8:0]  trk_x;
    logic [7:0]  trk_y, trk_start, trk_dx, trk_dy;
    logic [3:0]  trk_btn;
    logic [1:0]  trk_warm, trk_src;
    bit          trk_latched, trk_settle;
    logic [15:0] trk_cnt [4];

    t_report expected_reports [$];
    int      err_count = 0;
    int      n_polls = 0;
    int      n_results = 0;
    int      n_sampled = 0;
    int      n_moved = 0;
    int      burst_left = 0;
    int      n_settings = 1;

    logic [7:0] stall_cyc = '0;
    int         stall_mode = 0;

    t_dir_row dir_tab [DirRows] = '{
        // After reset nothing has moved.
        '{0,    0,    0,    0, 0,    0,    0, 1, 160, 100, 0, 0, 0},
        '{179,  -128, -128, 3, -128, -128, 3, 1, 160, 100, 0, 0, 0},
        // One line short of the settle window.
        '{199,  127,  127,  3, 127,  127,  3, 1, 160, 100, 0, 0, 0},
        '{200,  0,    0,    0, 0,    0,    0, 1, 160, 100, 0, 1, 0},
        '{225,  1,    1,    1, 1,    1,    1, 1, 160, 100, 0, 1, 0},
        // Warmup sample: full motion and buttons are ignored.
        '{226,  127,  127,  3, 127,  127,  3, 1, 160, 100, 1, 0, 1},
        '{255,  5,    5,    1, 5,    5,    1, 1, 160, 100, 0, 0, 1},
        // Line 180 leaves the latch set, line 179 clears it.
        '{180,  0,    0,    0, 0,    0,    0, 1, 160, 100, 0, 0, 1},
        '{179,  0,    0,    0, 0,    0,    0, 1, 160, 100, 0, 0, 1},
        '{210,  0,    0,    0, 0,    0,    0, 1, 160, 100, 0, 1, 1},
        // The line distance wraps past 255, so line 180 already qualifies.
        '{180,  -128, -128, 3, -128, -128, 3, 1, 160, 100, 1, 0, 2},
        '{0,    0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{200,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{226,  127,  127,  3, 127,  127,  3, 0, 0, 0, 0, 0, 0},
        '{10,   0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{250,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{20,   -128, -128, 2, -128, -128, 1, 0, 0, 0, 0, 0, 0},
        '{100,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{230,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{0,    127,  0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{50,   0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{200,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{255,  100,  0,    0, 0,    -128, 0, 0, 0, 0, 0, 0, 0},
        '{3,    0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{201,  0,    0,    0, 0,    0,    0, 0, 0, 0, 0, 0, 0},
        '{227,  -128, 127,  0, 0,    0,    2, 0, 0, 0, 0, 0, 0}
    };

    function automatic int clamp_step(int pos, int d, int lo, int hi);
        if (d < 0) begin
            return (pos < lo - d) ? lo : pos + d;
        end
        return (pos > hi - d) ? hi : pos + d;
    endfunction

    task automatic reset_tracker();
        cfg_xlo = fgpt_pkg::XLowerReset;
        cfg_xhi = fgpt_pkg::XUpperReset;
        cfg_ylo = fgpt_pkg::YLowerReset;
        cfg_yhi = fgpt_pkg::YUpperReset;
        cfg_xstart = fgpt_pkg::XStartReset;
        cfg_ystart = fgpt_pkg::YStartReset;
        cfg_warm = fgpt_pkg::WarmupReset;
        cfg_settle = fgpt_pkg::SettleReset;
        trk_x = cfg_xstart;
        trk_y = cfg_ystart;
        trk_btn = '0;
        trk_latched = 0;
        trk_settle = 0;
        trk_start = '0;
        trk_warm = cfg_warm;
        trk_src = '0;
        trk_dx = '0;
        trk_dy = '0;
        foreach (trk_cnt[k]) trk_cnt[k] = '0;
    endtask

    function automatic t_report track_poll(t_poll p);
        bit         take;
        logic [7:0] line_gap;
        int         mdx, mdy, jdx, jdy;
        logic [1:0] mb, jb, src;
        t_report    r;
        take = 0;
        if (p.line < fgpt_pkg::LatchClearLine && !trk_settle) trk_latched = 0;
        if (!trk_latched) begin
            line_gap = p.line - trk_start;
            if (!trk_settle) begin
                if (p.line >= fgpt_pkg::SettleOpenLine) begin
                    trk_settle = 1;
                    trk_start = p.line;
                end
            end else if (line_gap >= cfg_settle) begin
                take = 1;
            end
        end
        if (take) begin
            mdx = p.mdx;
            mdy = p.mdy;
            jdx = p.jdx;
            jdy = p.jdy;
            mb = p.mbtn;
            jb = p.jbtn;
            src = '0;
            if (trk_warm != 0) begin
                trk_warm = trk_warm - 1;
                mdx = 0;
                mdy = 0;
                jdx = 0;
                jdy = 0;
                mb = '0;
                jb = '0;
            end
            trk_dx = 8'(mdx + jdx);
            trk_dy = 8'(mdy + jdy);
            if (mdx != 0 || mdy != 0 || mb != 0) src[0] = 1'b1;
            if (jdx != 0 || jdy != 0 || jb != 0) src[1] = 1'b1;
            // Any motion re-clamps both axes, even one with zero delta.
            if (trk_dx != 0 || trk_dy != 0) begin
                trk_x = 9'(clamp_step(int'(trk_x), int'($signed(trk_dx)),
                                      int'(cfg_xlo), int'(cfg_xhi)));
                trk_y = 8'(clamp_step(int'(trk_y), int'($signed(trk_dy)),
                                      int'(cfg_ylo), int'(cfg_yhi)));
                trk_cnt[1]++;
            end
            if (src[0]) trk_cnt[2]++;
            if (src[1]) trk_cnt[3]++;
            trk_btn = {jb, mb};
            trk_src = src;
            trk_cnt[0]++;
            trk_settle = 0;
            trk_latched = 1;
        end
        r.pos_x = trk_x;
        r.pos_y = trk_y;
        r.btn = trk_btn;
        r.sampled = take;
        r.settling = trk_settle;
        r.src = trk_src;
        r.sdx = trk_dx;
        r.sdy = trk_dy;
        r.n_samp = trk_cnt[0];
        r.n_move = trk_cnt[1];
        r.n_mouse = trk_cnt[2];
        r.n_joy = trk_cnt[3];
        return r;
    endfunction

    task automatic push_poll(t_poll p, bit typed, t_report want);
        t_report pred;
        s_axis_tdata <= {{(fgpt_pkg::InDataW - $bits(t_poll)){1'b0}}, p};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = track_poll(p);
        expected_reports.push_back(typed ? want : pred);
        n_polls++;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    // Hold the source off until every result has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(fgpt_pkg::t_cfg_idx idx, logic [8:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            fgpt_pkg::CFG_X_LOWER: cfg_xlo = val;
            fgpt_pkg::CFG_X_UPPER: cfg_xhi = val;
            fgpt_pkg::CFG_Y_LOWER: cfg_ylo = val[7:0];
            fgpt_pkg::CFG_Y_UPPER: cfg_yhi = val[7:0];
            fgpt_pkg::CFG_X_START: begin
                cfg_xstart = val;
                trk_x = val;
            end
            fgpt_pkg::CFG_Y_START: begin
                cfg_ystart = val[7:0];
                trk_y = val[7:0];
            end
            fgpt_pkg::CFG_WARMUP: begin
                cfg_warm = val[1:0];
                trk_warm = val[1:0];
            end
            fgpt_pkg::CFG_SETTLE: cfg_settle = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int xlo, int xhi, int ylo, int yhi, int xs, int ys,
                            int wu, int st);
        write_reg(fgpt_pkg::CFG_X_LOWER, 9'(xlo));
        write_reg(fgpt_pkg::CFG_X_UPPER, 9'(xhi));
        write_reg(fgpt_pkg::CFG_Y_LOWER, 9'(ylo));
        write_reg(fgpt_pkg::CFG_Y_UPPER, 9'(yhi));
        write_reg(fgpt_pkg::CFG_X_START, 9'(xs));
        write_reg(fgpt_pkg::CFG_Y_START, 9'(ys));
        write_reg(fgpt_pkg::CFG_WARMUP, 9'(wu));
        write_reg(fgpt_pkg::CFG_SETTLE, 9'(st));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    function automatic logic [7:0] rand_delta();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) return 8'd0;
        if (k < 7) return 8'($urandom_range(0, 8) - 4);
        return 8'($urandom);
    endfunction

    // Mostly forward raster sweeps, so frames open, settle and sample; the
    // rest are lines out of nowhere.
    task automatic run_phase(int n_items, int noise_pct, int step_hi);
        logic [7:0] line, prev;
        int         step_max;
        t_poll      p;
        t_report    none;
        none = '0;
        line = 8'($urandom_range(0, 255));
        step_max = $urandom_range(1, step_hi);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                p.line = 8'($urandom_range(0, 255));
            end else begin
                prev = line;
                line = line + 8'($urandom_range(1, step_max));
                if (line < prev) step_max = $urandom_range(1, step_hi);
                p.line = line;
            end
            p.mdx = rand_delta();
            p.mdy = rand_delta();
            p.jdx = rand_delta();
            p.jdy = rand_delta();
            p.mbtn = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
            p.jbtn = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
            push_poll(p, 0, none);
            if ($urandom_range(0, 199) == 0) drain_results();
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(t_report got);
        t_report want;
        if (expected_reports.size() == 0) begin
            $error("result beat with no poll outstanding");
            err_count++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("button_bits", want.btn, got.btn);
        check_field("sampled", want.sampled, got.sampled);
        check_field("settling", want.settling, got.settling);
        check_field("source_bits", want.src, got.src);
        check_field("sum_dx", want.sdx, got.sdx);
        check_field("sum_dy", want.sdy, got.sdy);
        check_field("sample_total", want.n_samp, got.n_samp);
        check_field("move_total", want.n_move, got.n_move);
        check_field("mouse_total", want.n_mouse, got.n_mouse);
        check_field("joy_total", want.n_joy, got.n_joy);
        n_results++;
        if (got.sampled) n_sampled++;
        if (got.sampled && (got.sdx != 0 || got.sdy != 0)) n_moved++;
    endtask

    // Sink side: check each result beat, and stall in a mode that is redrawn
    // at random whenever stall_cyc[6:0] returns to zero.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result(t_report'(m_axis_tdata[$bits(t_report)-1:0]));
        end
        stall_cyc <= stall_cyc + 8'd1;
        if (stall_cyc[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (stall_cyc[1:0] == 2'd0);
            default: m_axis_tready <= stall_cyc[3];
        endcase
    end

    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        t_poll   p;
        t_report want;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_tracker();

        foreach (dir_tab[i]) begin
            p.line = 8'(dir_tab[i].line);
            p.mdx = 8'(dir_tab[i].mdx);
            p.mdy = 8'(dir_tab[i].mdy);
            p.mbtn = 2'(dir_tab[i].mb);
            p.jdx = 8'(dir_tab[i].jdx);
            p.jdy = 8'(dir_tab[i].jdy);
            p.jbtn = 2'(dir_tab[i].jb);
            // Typed rows all precede the first real motion, so the fields
            // not listed in the table are still zero.
            want = '0;
            want.pos_x = 9'(dir_tab[i].px);
            want.pos_y = 8'(dir_tab[i].py);
            want.sampled = 1'(dir_tab[i].smp);
            want.settling = 1'(dir_tab[i].stl);
            want.n_samp = 16'(dir_tab[i].nsamp);
            push_poll(p, dir_tab[i].typed, want);
        end

        run_phase(400, 15, 40);
        drain_results();
        set_regs(0, 511, 0, 255, 511, 255, 0, 0);
        run_phase(350, 15, 40);
        drain_results();
        // Inverted bounds, longest warmup.
        set_regs(400, 10, 200, 50, 0, 0, 3, 40);
        run_phase(350, 15, 40);
        drain_results();
        // Longest settle time: only the line just before the opening one
        // qualifies, so the sweep moves one line at a time.
        set_regs(511, 511, 255, 255, 0, 0, 1, 255);
        run_phase(250, 5, 1);
        drain_results();
        set_regs($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 3), $urandom_range(0, 60));
        run_phase(350, 15, 40);
        drain_results();

        $display("Covered %0d polls and %0d results under %0d register settings,",
                 n_polls, n_results, n_settings);
        $display("with %0d frame samples, %0d of them moving the pointer.",
                 n_sampled, n_moved);
        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
